[hw/rtl/lsf_pkg.sv]
// Shared constants, codes and types of the 3x3 Laplacian sharpening filter.
// Depends on nothing; every other file of the block imports it.
package lsf_pkg;

  localparam int unsigned MAX_WIDTH    = 2048;
  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned ADDR_W       = $clog2(STORE_DEPTH);

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned WIDTH_W  = 12;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned LEN_W    = ADDR_W + 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  // Input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
  localparam logic [CHAN_W-1:0]   CHAN_RST   = 3'd3;

  // Per-item control handed from the sequencer to the filter stage
  typedef struct packed {
    logic emit;      // item produces a result word
    logic interior;  // result is filtered, otherwise zero
    logic last;      // final word of the frame
    logic sel;       // bank role select at accept time
  } lsf_item_t;

  // Three registered reads of one line bank: p-c, p, p+c
  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] hi;
  } lsf_taps_t;

endpackage

[hw/rtl/lsf_line_bank.sv]
// One line bank: single write port, three registered read ports.
// Two identical copies back the three reads. Depends on lsf_pkg.
module lsf_line_bank
  import lsf_pkg::*;
#(
  parameter int unsigned DEPTH = STORE_DEPTH,
  parameter int unsigned WIDTH = PIX_W
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] ra_lo_i,
  input  logic [$clog2(DEPTH)-1:0] ra_mid_i,
  input  logic [$clog2(DEPTH)-1:0] ra_hi_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wa_i,
  input  logic [WIDTH-1:0]         wd_i,
  output logic [WIDTH-1:0]         rd_lo_o,
  output logic [WIDTH-1:0]         rd_mid_o,
  output logic [WIDTH-1:0]         rd_hi_o
);

  logic [WIDTH-1:0] mem_a [DEPTH];
  logic [WIDTH-1:0] mem_b [DEPTH];

  // Read first: a read and a write at one address return the old word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_lo_o  <= mem_a[ra_lo_i];
      rd_mid_o <= mem_a[ra_mid_i];
    end
    if (we_i) begin
      mem_a[wa_i] <= wd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_hi_o <= mem_b[ra_hi_i];
    end
    if (we_i) begin
      mem_b[wa_i] <= wd_i;
    end
  end

endmodule

[hw/rtl/lsf_seq.sv]
// Sequencer: configuration registers, raster counters, bank addressing and
// per-item control. Depends on lsf_pkg.
module lsf_seq
  import lsf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  command_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  output lsf_item_t             item_o,
  output logic [ADDR_W-1:0]     ra_lo_o,
  output logic [ADDR_W-1:0]     ra_mid_o,
  output logic [ADDR_W-1:0]     ra_hi_o,
  output logic [1:0]            we_o,
  output logic [ADDR_W-1:0]     wa_o
);

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [CHAN_W-1:0]   chan_q;

  logic [HEIGHT_W-1:0] row_q,   row_d;
  logic [ADDR_W-1:0]   samp_q,  samp_d;
  logic [ADDR_W-1:0]   drain_q, drain_d;
  logic                sel_q,   sel_d;

  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [CHAN_W-1:0]   c_eff;
  logic [LEN_W-1:0]    len;
  logic                draining;
  logic [ADDR_W-1:0]   c_addr;
  logic [ADDR_W-1:0]   x_pos;
  logic [27:0]         div3_prod;
  logic                samp_end;
  logic                drain_end;
  logic                wr_en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      chan_q   <= CHAN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:   width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:  height_q <= cfg_data_i[HEIGHT_W-1:0];
        REG_CHANNEL_COUNT: chan_q   <= cfg_data_i[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to the supported ranges
  always_comb begin
    w_eff = width_q;
    if (width_q < WIDTH_W'(3)) begin
      w_eff = WIDTH_W'(3);
    end else if ({1'b0, width_q} > (WIDTH_W + 1)'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end
    h_eff = (height_q < HEIGHT_W'(3)) ? HEIGHT_W'(3) : height_q;
    c_eff = chan_q;
    if (chan_q == '0) begin
      c_eff = CHAN_W'(1);
    end else if (chan_q > CHAN_W'(MAX_CHANNELS)) begin
      c_eff = CHAN_W'(MAX_CHANNELS);
    end
  end

  assign len      = LEN_W'(LEN_W'(w_eff) * LEN_W'(c_eff));
  assign draining = (row_q >= h_eff);
  assign c_addr   = ADDR_W'(c_eff);

  // Pixel column of the current sample: sample index over channel count
  assign div3_prod = 28'(samp_q) * 28'(15'd10923);
  always_comb begin
    case (c_eff)
      3'd1:    x_pos = samp_q;
      3'd2:    x_pos = samp_q >> 1;
      3'd3:    x_pos = div3_prod[27:15];
      default: x_pos = samp_q >> 2;
    endcase
  end

  assign samp_end  = ({1'b0, samp_q} + LEN_W'(1)) >= len;
  assign drain_end = ({1'b0, drain_q} + LEN_W'(1)) >= len;

  always_comb begin
    item_o.sel      = sel_q;
    item_o.interior = 1'b0;
    item_o.last     = 1'b0;
    item_o.emit     = 1'b0;
    wr_en           = 1'b0;
    if (command_i == CMD_DRAIN) begin
      item_o.emit = draining;
      item_o.last = drain_end;
    end else begin
      wr_en           = !draining;
      item_o.emit     = !draining && (row_q != '0);
      item_o.interior = (row_q >= HEIGHT_W'(2)) && (x_pos != '0)
                        && (({1'b0, x_pos} + LEN_W'(1)) < LEN_W'(w_eff));
    end
  end

  assign ra_lo_o  = samp_q - c_addr;
  assign ra_mid_o = samp_q;
  assign ra_hi_o  = samp_q + c_addr;
  assign wa_o     = samp_q;
  // Write the incoming sample into whichever bank holds the older row
  assign we_o     = {accept_i && wr_en && sel_q, accept_i && wr_en && !sel_q};

  always_comb begin
    row_d   = row_q;
    samp_d  = samp_q;
    drain_d = drain_q;
    sel_d   = sel_q;
    if (accept_i) begin
      if (command_i == CMD_DRAIN) begin
        if (draining) begin
          if (drain_end) begin
            row_d   = '0;
            samp_d  = '0;
            drain_d = '0;
            sel_d   = 1'b0;
          end else begin
            drain_d = drain_q + ADDR_W'(1);
          end
        end
      end else if (!draining) begin
        if (samp_end) begin
          samp_d = '0;
          row_d  = row_q + HEIGHT_W'(1);
          sel_d  = !sel_q;
        end else begin
          samp_d = samp_q + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      samp_q  <= '0;
      drain_q <= '0;
      sel_q   <= 1'b0;
    end else begin
      row_q   <= row_d;
      samp_q  <= samp_d;
      drain_q <= drain_d;
      sel_q   <= sel_d;
    end
  end

endmodule

[hw/rtl/lsf_kernel.sv]
// Filter stage: input register (with the banks' read registers), the 3x3
// Laplacian arithmetic and the result register. Depends on lsf_pkg.
module lsf_kernel
  import lsf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             accept_o,
  input  lsf_item_t        item_i,
  input  logic [PIX_W-1:0] sample_i,
  input  lsf_taps_t        bank0_i,
  input  lsf_taps_t        bank1_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PIX_W-1:0] pixel_out_o,
  output logic             frame_last_o
);

  logic             s1_v_q;
  lsf_item_t        s1_item_q;
  logic [PIX_W-1:0] s1_down_q;

  logic             out_v_q;
  logic [PIX_W-1:0] pix_q;
  logic             last_q;

  logic             out_free;
  logic             s1_free;
  lsf_taps_t        newer;
  lsf_taps_t        older;
  logic signed [11:0] lap;
  logic [PIX_W-1:0] sat;

  assign out_free   = !out_v_q || !out_stall_i;
  assign s1_free    = !s1_v_q || out_free;
  assign in_stall_o = !s1_free;
  assign accept_o   = in_valid_i && s1_free;

  // Role select: zero means bank 1 holds the previous row
  assign newer = s1_item_q.sel ? bank0_i : bank1_i;
  assign older = s1_item_q.sel ? bank1_i : bank0_i;

  assign lap = $signed({2'b00, newer.mid, 2'b00}) + $signed({4'b0000, newer.mid})
             - $signed({4'b0000, newer.lo}) - $signed({4'b0000, newer.hi})
             - $signed({4'b0000, older.mid}) - $signed({4'b0000, s1_down_q});

  always_comb begin
    if (lap < 12'sd0) begin
      sat = '0;
    end else if (lap > 12'sd255) begin
      sat = '1;
    end else begin
      sat = lap[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept_o) begin
        s1_v_q <= item_i.emit;
      end else if (out_free) begin
        s1_v_q <= 1'b0;
      end
      if (out_free) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      s1_item_q <= item_i;
      s1_down_q <= sample_i;
    end
    if (out_free && s1_v_q) begin
      pix_q  <= s1_item_q.interior ? sat : '0;
      last_q <= s1_item_q.last;
    end
  end

  assign out_valid_o  = out_v_q;
  assign pixel_out_o  = pix_q;
  assign frame_last_o = last_q;

`ifndef SYNTHESIS
  a_full_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && out_v_q && out_stall_i |-> in_stall_o)
    else $error("input taken while both stages are blocked");

  a_emit_fills_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_o && item_i.emit |=> s1_v_q)
    else $error("emitting word lost at stage entry");

  a_last_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && last_q |-> pix_q == '0)
    else $error("final word of the frame is not a border zero");

  a_stage_moves_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && out_free |=> out_v_q)
    else $error("filtered word did not reach the result register");
`endif

endmodule

[hw/rtl/laplacian_sharpen_3x3.sv]
// Top level of the 3x3 Laplacian sharpening filter over an interleaved
// raster stream. Depends on lsf_pkg, lsf_seq, lsf_line_bank, lsf_kernel.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o  command_i, sample_i
//   out      source     out_valid_o/out_stall_i pixel_out_o, frame_last_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One word per cycle in and out while the output does not stall; a result
// passes the bank read register, then the result register. The rate is set by the
// line banks: each gives three reads and one write per cycle.
// Reset clears counters, bank roles and the registers to 640x480, 3 channels;
// the line banks are not cleared; no unwritten entry reaches a filtered result.
// A stall on the output holds the result register, then the filter stage,
// then stalls the input; nothing is dropped.
module laplacian_sharpen_3x3
  import lsf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [PIX_W-1:0]      sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic                  frame_last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic              accept;
  lsf_item_t         item;
  logic [ADDR_W-1:0] ra_lo;
  logic [ADDR_W-1:0] ra_mid;
  logic [ADDR_W-1:0] ra_hi;
  logic [1:0]        we;
  logic [ADDR_W-1:0] wa;
  lsf_taps_t         bank0;
  lsf_taps_t         bank1;

  // Counters, configuration and addressing for the word at the input
  lsf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (command_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .item_o      (item),
    .ra_lo_o     (ra_lo),
    .ra_mid_o    (ra_mid),
    .ra_hi_o     (ra_hi),
    .we_o        (we),
    .wa_o        (wa)
  );

  // Two row banks; roles swap at every row end. Both read on each accept,
  // the filter stage picks older and newer.
  lsf_line_bank u_bank0 (
    .clk_i    (clk_i),
    .re_i     (accept),
    .ra_lo_i  (ra_lo),
    .ra_mid_i (ra_mid),
    .ra_hi_i  (ra_hi),
    .we_i     (we[0]),
    .wa_i     (wa),
    .wd_i     (sample_i),
    .rd_lo_o  (bank0.lo),
    .rd_mid_o (bank0.mid),
    .rd_hi_o  (bank0.hi)
  );

  lsf_line_bank u_bank1 (
    .clk_i    (clk_i),
    .re_i     (accept),
    .ra_lo_i  (ra_lo),
    .ra_mid_i (ra_mid),
    .ra_hi_i  (ra_hi),
    .we_i     (we[1]),
    .wa_i     (wa),
    .wd_i     (sample_i),
    .rd_lo_o  (bank1.lo),
    .rd_mid_o (bank1.mid),
    .rd_hi_o  (bank1.hi)
  );

  // Arithmetic, saturation and output handshake
  lsf_kernel u_kernel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .accept_o     (accept),
    .item_i       (item),
    .sample_i     (sample_i),
    .bank0_i      (bank0),
    .bank1_i      (bank1),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

endmodule
